// ===== design/bbd_pkg.sv =====
// shared types and constants for the box blur and 2:1 decimation block
package bbd_pkg;

    localparam int PIX_W      = 8;
    localparam int WIDTH_W    = 10;
    localparam int HEIGHT_W   = 13;
    localparam int CFG_DATA_W = 13;
    localparam int DIM_W      = 13;
    localparam int ROW_W      = 12;
    localparam int MIN_DIM    = 4;
    localparam int MAX_HEIGHT = 4096;
    localparam int ROW_SUM_W  = 10;
    localparam int SUM_W      = 12;

    // floor(x / 9) = (x * ceil(2^15 / 9)) >> 15, exact for x < 2^15
    localparam logic [SUM_W-1:0] DIV9_MUL = SUM_W'(3641);
    localparam int DIV9_SHIFT = 15;

    localparam logic [WIDTH_W-1:0]  RST_WIDTH  = WIDTH_W'(512);
    localparam logic [HEIGHT_W-1:0] RST_HEIGHT = HEIGHT_W'(512);

    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_reg_index;

    // per-pixel control that rides along the pipeline
    typedef struct packed {
        logic emit;
        logic zero_mean;
        logic last;
    } t_tag;

    // [row][col], row 0 oldest line, col 2 newest pixel
    typedef logic [2:0][2:0][PIX_W-1:0] t_win;

endpackage

// ===== design/bbd_ram.sv =====
// generic simple dual-port ram with registered read
module bbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/bbd_window.sv =====
// line stores and 3x3 window stage
module bbd_window #(
    parameter int MAX_WIDTH = 512
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_acc,
    input  logic [bbd_pkg::PIX_W-1:0]    i_pixel,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_col,
    input  bbd_pkg::t_tag                i_tag,
    output logic                         o_in_ready,
    output logic                         o_win_valid,
    input  logic                         i_win_ready,
    output bbd_pkg::t_win                o_win,
    output bbd_pkg::t_tag                o_tag
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic                      r_s1_valid;
    logic [bbd_pkg::PIX_W-1:0] r_s1_pixel;
    logic [CW-1:0]             r_s1_col;
    bbd_pkg::t_tag             r_s1_tag;
    logic                      r_s2_valid;
    bbd_pkg::t_tag             r_s2_tag;
    bbd_pkg::t_win             r_win;
    bbd_pkg::t_win             n_win;
    logic [bbd_pkg::PIX_W-1:0] top_pix;
    logic [bbd_pkg::PIX_W-1:0] mid_pix;
    logic                      s2_ready;
    logic                      s1_adv;

    // window holds the stage-2 word, so it may only shift when stage 2 frees
    assign s2_ready   = !r_s2_valid || i_win_ready;
    assign s1_adv     = r_s1_valid && s2_ready;
    assign o_in_ready = !r_s1_valid || s1_adv;

    bbd_ram #(.WIDTH(bbd_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_older (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_col),
        .i_wdata (mid_pix),
        .i_re    (i_acc),
        .i_raddr (i_col),
        .o_rdata (top_pix)
    );

    bbd_ram #(.WIDTH(bbd_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_newer (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_col),
        .i_wdata (r_s1_pixel),
        .i_re    (i_acc),
        .i_raddr (i_col),
        .o_rdata (mid_pix)
    );

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_win[r][0] = r_win[r][1];
            n_win[r][1] = r_win[r][2];
        end
        n_win[0][2] = top_pix;
        n_win[1][2] = mid_pix;
        n_win[2][2] = r_s1_pixel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_win      <= '0;
        end else begin
            if (i_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_s2_valid <= r_s1_tag.emit;
                r_win      <= n_win;
            end else if (i_win_ready) begin
                r_s2_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_s1_pixel <= i_pixel;
            r_s1_col   <= i_col;
            r_s1_tag   <= i_tag;
        end
        if (s1_adv) begin
            r_s2_tag <= r_s1_tag;
        end
    end

    assign o_win_valid = r_s2_valid;
    assign o_win       = r_win;
    assign o_tag       = r_s2_tag;

endmodule

// ===== design/bbd_mean.sv =====
// 3x3 sum, divide by nine and output register
module bbd_mean (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_win_valid,
    output logic                      o_win_ready,
    input  bbd_pkg::t_win             i_win,
    input  bbd_pkg::t_tag             i_tag,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [bbd_pkg::PIX_W-1:0] o_blurred_value,
    output logic [bbd_pkg::PIX_W-1:0] o_plain_value,
    output logic                      o_last_of_frame
);

    localparam int PROD_W = 2 * bbd_pkg::SUM_W;
    localparam int MEAN_LO = bbd_pkg::DIV9_SHIFT;
    localparam int MEAN_HI = bbd_pkg::DIV9_SHIFT + bbd_pkg::PIX_W - 1;

    logic                          r_s3_valid;
    logic [2:0][bbd_pkg::ROW_SUM_W-1:0] r_s3_rsum;
    logic [2:0][bbd_pkg::ROW_SUM_W-1:0] n_rsum;
    logic [bbd_pkg::PIX_W-1:0]     r_s3_plain;
    bbd_pkg::t_tag                 r_s3_tag;
    logic                          r_s4_valid;
    logic [bbd_pkg::SUM_W-1:0]     r_s4_sum;
    logic [bbd_pkg::PIX_W-1:0]     r_s4_plain;
    bbd_pkg::t_tag                 r_s4_tag;
    logic                          r_out_valid;
    logic [bbd_pkg::PIX_W-1:0]     r_blurred;
    logic [bbd_pkg::PIX_W-1:0]     r_plain;
    logic                          r_last;
    logic [PROD_W-1:0]             prod;
    logic                          out_rdy;
    logic                          s4_rdy;
    logic                          s3_rdy;

    assign out_rdy     = !r_out_valid || i_out_ready;
    assign s4_rdy      = !r_s4_valid || out_rdy;
    assign s3_rdy      = !r_s3_valid || s4_rdy;
    assign o_win_ready = s3_rdy;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_rsum[r] = bbd_pkg::ROW_SUM_W'(i_win[r][0])
                      + bbd_pkg::ROW_SUM_W'(i_win[r][1])
                      + bbd_pkg::ROW_SUM_W'(i_win[r][2]);
        end
    end

    assign prod = r_s4_sum * bbd_pkg::DIV9_MUL;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s3_rdy) begin
                r_s3_valid <= i_win_valid;
            end
            if (s4_rdy) begin
                r_s4_valid <= r_s3_valid;
            end
            if (out_rdy) begin
                r_out_valid <= r_s4_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_rdy && i_win_valid) begin
            r_s3_rsum  <= n_rsum;
            r_s3_plain <= i_win[1][1];
            r_s3_tag   <= i_tag;
        end
        if (s4_rdy && r_s3_valid) begin
            r_s4_sum   <= bbd_pkg::SUM_W'(r_s3_rsum[0])
                        + bbd_pkg::SUM_W'(r_s3_rsum[1])
                        + bbd_pkg::SUM_W'(r_s3_rsum[2]);
            r_s4_plain <= r_s3_plain;
            r_s4_tag   <= r_s3_tag;
        end
        if (out_rdy && r_s4_valid) begin
            r_blurred <= r_s4_tag.zero_mean ? '0 : prod[MEAN_HI:MEAN_LO];
            r_plain   <= r_s4_plain;
            r_last    <= r_s4_tag.last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_blurred_value = r_blurred;
    assign o_plain_value   = r_plain;
    assign o_last_of_frame = r_last;

endmodule

// ===== design/box_blur_decimate_2to1_top.sv =====
// top level of the 3x3 box blur with 2:1 decimation in both directions
//
// usage:
//   input channel: one 8-bit grayscale pixel per word on i_pixel, raster order,
//   handshake i_in_valid / o_in_ready. output channel: one word per kept pixel
//   (even row, even column) with o_plain_value, o_blurred_value (3x3 sum / 9,
//   truncated, zero in row 0 or column 0) and o_last_of_frame, handshake
//   o_out_valid / i_out_ready.
//   the kept pixel (r,c) leaves with the input word that carries pixel
//   (r+1,c+1), so one output word comes for every fourth input word.
//   the input word that triggers an output passes the registered steps
//   line-store read, window shift, row sums, total and divide, in that order.
//   throughput: one input word per clock while the receiver keeps up; the line
//   stores are read at the new column and written back at the previous one.
//   i_cfg_we / i_cfg_index / i_cfg_data set the frame size; write only idle.
//   reset clears counters, window and pipeline valids and sets 512 x 512;
//   line stores are not cleared, their stale data only reach zeroed means.
//   when the receiver stalls, words back up stage by stage; input is still
//   taken until the first pipeline stage is full
module box_blur_decimate_2to1_top #(
    parameter int MAX_WIDTH = 512
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // pixel input
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [bbd_pkg::PIX_W-1:0]      i_pixel,
    // result output
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [bbd_pkg::PIX_W-1:0]      o_blurred_value,
    output logic [bbd_pkg::PIX_W-1:0]      o_plain_value,
    output logic                           o_last_of_frame,
    // configuration writes
    input  logic                           i_cfg_we,
    input  logic [0:0]                     i_cfg_index,
    input  logic [bbd_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int W_HI = MAX_WIDTH - (MAX_WIDTH % 2);
    localparam int H_HI = bbd_pkg::MAX_HEIGHT - (bbd_pkg::MAX_HEIGHT % 2);
    localparam logic [bbd_pkg::DIM_W-1:0] W_MAX = bbd_pkg::DIM_W'(W_HI);
    localparam logic [bbd_pkg::DIM_W-1:0] H_MAX = bbd_pkg::DIM_W'(H_HI);
    localparam logic [bbd_pkg::DIM_W-1:0] D_MIN = bbd_pkg::DIM_W'(bbd_pkg::MIN_DIM);

    // configuration registers
    logic [bbd_pkg::WIDTH_W-1:0]  r_image_width;
    logic [bbd_pkg::HEIGHT_W-1:0] r_image_height;

    // raster position of the next input pixel
    logic [CW-1:0]            r_col;
    logic [bbd_pkg::ROW_W-1:0] r_row;

    logic [bbd_pkg::DIM_W-1:0] w_even;
    logic [bbd_pkg::DIM_W-1:0] h_even;
    logic [bbd_pkg::DIM_W-1:0] w_eff;
    logic [bbd_pkg::DIM_W-1:0] h_eff;
    logic                      row_end;
    logic                      frame_end;
    logic                      in_acc;
    bbd_pkg::t_tag             in_tag;

    logic                      win_valid;
    logic                      win_ready;
    bbd_pkg::t_win             win;
    bbd_pkg::t_tag             win_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= bbd_pkg::RST_WIDTH;
            r_image_height <= bbd_pkg::RST_HEIGHT;
        end else if (i_cfg_we) begin
            case (bbd_pkg::t_reg_index'(i_cfg_index))
                bbd_pkg::REG_IMAGE_WIDTH: begin
                    r_image_width <= i_cfg_data[bbd_pkg::WIDTH_W-1:0];
                end
                bbd_pkg::REG_IMAGE_HEIGHT: begin
                    r_image_height <= i_cfg_data[bbd_pkg::HEIGHT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // effective frame size: low bit dropped, then clamped to the legal range
    always_comb begin
        w_even = bbd_pkg::DIM_W'({r_image_width[bbd_pkg::WIDTH_W-1:1], 1'b0});
        h_even = {r_image_height[bbd_pkg::HEIGHT_W-1:1], 1'b0};
        if (w_even < D_MIN) begin
            w_eff = D_MIN;
        end else if (w_even > W_MAX) begin
            w_eff = W_MAX;
        end else begin
            w_eff = w_even;
        end
        if (h_even < D_MIN) begin
            h_eff = D_MIN;
        end else if (h_even > H_MAX) begin
            h_eff = H_MAX;
        end else begin
            h_eff = h_even;
        end
    end

    // end of row / frame for the pixel now at the input
    assign row_end   = bbd_pkg::DIM_W'(r_col) >= (w_eff - 1'b1);
    assign frame_end = row_end && (bbd_pkg::DIM_W'(r_row) >= (h_eff - 1'b1));
    assign in_acc    = i_in_valid && o_in_ready;

    // a result leaves on odd row and odd column: it belongs to the pixel
    // one up and one left, which sits at the window center
    assign in_tag.emit      = r_row[0] && r_col[0];
    assign in_tag.zero_mean = (r_row == bbd_pkg::ROW_W'(1)) || (r_col == CW'(1));
    assign in_tag.last      = frame_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            if (row_end) begin
                r_col <= '0;
                r_row <= frame_end ? '0 : r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    bbd_window #(.MAX_WIDTH(MAX_WIDTH)) u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_acc       (in_acc),
        .i_pixel     (i_pixel),
        .i_col       (r_col),
        .i_tag       (in_tag),
        .o_in_ready  (o_in_ready),
        .o_win_valid (win_valid),
        .i_win_ready (win_ready),
        .o_win       (win),
        .o_tag       (win_tag)
    );

    bbd_mean u_mean (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_win_valid     (win_valid),
        .o_win_ready     (win_ready),
        .i_win           (win),
        .i_tag           (win_tag),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_blurred_value (o_blurred_value),
        .o_plain_value   (o_plain_value),
        .o_last_of_frame (o_last_of_frame)
    );

endmodule

// ===== verif/box_blur_decimate_2to1_top_tb.sv =====
// self-checking testbench for the 3x3 box blur with 2:1 decimation, directed and random frames
module box_blur_decimate_2to1_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 10;
    localparam int LINE_DEPTH   = 512;
    localparam int BOX_AREA     = 9;
    // settle time after the last owed word, before touching registers
    localparam int DRAIN_CYCLES = 12;
    // far beyond the slowest legal run (about 2000 words with stalls)
    localparam int RUN_LIMIT_NS = 5_000_000;

    // one output word as the block should deliver it
    typedef struct packed {
        logic [bbd_pkg::PIX_W-1:0] blurred;
        logic [bbd_pkg::PIX_W-1:0] plain;
        logic                      last;
    } t_kept_pixel;

    // content flavor of a random frame
    typedef enum int {
        PIX_ANY,
        PIX_RAILS,
        PIX_DARK,
        PIX_BRIGHT
    } t_pix_style;

    // dut ports, every input known from time zero
    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_in_valid  = 1'b0;
    logic                           o_in_ready;
    logic [bbd_pkg::PIX_W-1:0]      i_pixel     = '0;
    logic                           o_out_valid;
    logic                           i_out_ready = 1'b0;
    logic [bbd_pkg::PIX_W-1:0]      o_blurred_value;
    logic [bbd_pkg::PIX_W-1:0]      o_plain_value;
    logic                           o_last_of_frame;
    logic                           i_cfg_we    = 1'b0;
    logic [0:0]                     i_cfg_index = '0;
    logic [bbd_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;

    // predictor state: two line stores, 3x3 window, raster position, raw registers
    logic [bbd_pkg::PIX_W-1:0]    line_two_up [LINE_DEPTH];
    logic [bbd_pkg::PIX_W-1:0]    line_one_up [LINE_DEPTH];
    bbd_pkg::t_win                blur_win;
    int unsigned                  col_pos;
    int unsigned                  row_pos;
    logic [bbd_pkg::WIDTH_W-1:0]  width_reg;
    logic [bbd_pkg::HEIGHT_W-1:0] height_reg;

    // output words still owed by the block, oldest first
    t_kept_pixel kept_due[$];

    int error_count     = 0;
    // idling knobs, percent of cycles
    int send_gap_pct    = 0;
    int ready_stall_pct = 0;
    // receiver hold-off, counted down by the receiver process
    int hold_off_left   = 0;

    box_blur_decimate_2to1_top #(
        .MAX_WIDTH(LINE_DEPTH)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_pixel(i_pixel),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_blurred_value(o_blurred_value),
        .o_plain_value(o_plain_value),
        .o_last_of_frame(o_last_of_frame),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // force even, then saturate into [MIN_DIM, top]
    function automatic int unsigned clamp_dim(input int unsigned raw, input int unsigned top);
        int unsigned dim;
        dim = raw & 32'hFFFF_FFFE;
        if (dim < bbd_pkg::MIN_DIM) dim = bbd_pkg::MIN_DIM;
        if (dim > top) dim = top;
        return dim;
    endfunction

    // state after reset; unwritten line entries read as zero but never reach a mean
    task automatic clear_blur_state();
        foreach (line_two_up[i]) begin
            line_two_up[i] = '0;
            line_one_up[i] = '0;
        end
        blur_win   = '0;
        col_pos    = 0;
        row_pos    = 0;
        width_reg  = bbd_pkg::RST_WIDTH;
        height_reg = bbd_pkg::RST_HEIGHT;
    endtask

    // advance the predictor by one accepted pixel, queue the kept word if any
    task automatic predict_kept_pixel(input logic [bbd_pkg::PIX_W-1:0] pix);
        int unsigned               cols;
        int unsigned               rows;
        int unsigned               box_sum;
        int                        r;
        int                        c;
        logic [bbd_pkg::PIX_W-1:0] top_px;
        logic [bbd_pkg::PIX_W-1:0] mid_px;
        logic                      row_end;
        logic                      frame_end;
        t_kept_pixel               kp;
        cols = clamp_dim(width_reg, LINE_DEPTH);
        rows = clamp_dim(height_reg, bbd_pkg::MAX_HEIGHT);
        // line stores shift down one row at this column
        top_px = line_two_up[col_pos];
        mid_px = line_one_up[col_pos];
        line_two_up[col_pos] = mid_px;
        line_one_up[col_pos] = pix;
        // window keeps shifting left, even across row ends
        for (r = 0; r < 3; r++) begin
            blur_win[r][0] = blur_win[r][1];
            blur_win[r][1] = blur_win[r][2];
        end
        blur_win[0][2] = top_px;
        blur_win[1][2] = mid_px;
        blur_win[2][2] = pix;
        // >= so that a width or height shrunk mid-frame ends the row or frame at once
        row_end   = (col_pos >= cols - 1);
        frame_end = row_end && (row_pos >= rows - 1);
        // odd row and odd column: center (row-1, col-1) is a kept pixel
        if (row_pos[0] && col_pos[0]) begin
            box_sum = 0;
            for (r = 0; r < 3; r++) begin
                for (c = 0; c < 3; c++) begin
                    box_sum += blur_win[r][c];
                end
            end
            // kept pixel in row 0 or column 0 gets a zero mean
            kp.blurred = (row_pos != 1 && col_pos != 1) ?
                         bbd_pkg::PIX_W'(box_sum / BOX_AREA) : '0;
            kp.plain   = blur_win[1][1];
            kp.last    = frame_end;
            kept_due   = {kept_due, kp};
        end
        if (row_end) begin
            col_pos = 0;
            row_pos = frame_end ? 0 : row_pos + 1;
        end else begin
            col_pos++;
        end
    endtask

    function automatic logic [bbd_pkg::PIX_W-1:0] pick_pixel(input t_pix_style style);
        case (style)
            PIX_RAILS:  return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            PIX_DARK:   return bbd_pkg::PIX_W'($urandom_range(0, 3));
            PIX_BRIGHT: return bbd_pkg::PIX_W'($urandom_range(252, 255));
            default:    return bbd_pkg::PIX_W'($urandom);
        endcase
    endfunction

    // offer one word, with random gaps ahead of it, and wait for the handshake
    task automatic send_pixel(input logic [bbd_pkg::PIX_W-1:0] pix);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pixel    <= pix;
        do @(posedge i_clk); while (!o_in_ready);
        predict_kept_pixel(pix);
    endtask

    task automatic send_rows(input int unsigned rows, input int unsigned cols,
                             input t_pix_style style);
        repeat (rows * cols) send_pixel(pick_pixel(style));
    endtask

    // stop offering, let every owed word arrive, then let the pipeline settle
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (kept_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // both registers in back-to-back cycles, write enable held high between them
    task automatic set_frame(input logic [bbd_pkg::CFG_DATA_W-1:0] width_data,
                             input logic [bbd_pkg::CFG_DATA_W-1:0] height_data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= bbd_pkg::REG_IMAGE_WIDTH;
        i_cfg_data  <= width_data;
        @(posedge i_clk);
        width_reg    = bbd_pkg::WIDTH_W'(width_data);
        i_cfg_index <= bbd_pkg::REG_IMAGE_HEIGHT;
        i_cfg_data  <= height_data;
        @(posedge i_clk);
        height_reg = bbd_pkg::HEIGHT_W'(height_data);
        i_cfg_we  <= 1'b0;
    endtask

    // smallest frame from below-range values, every data bit toggled, full-scale mean
    task automatic test_corner_frame();
        logic [bbd_pkg::PIX_W-1:0] first_row [4] = '{8'h00, 8'h55, 8'hAA, 8'h01};
        set_frame(13'd0, 13'd1);
        foreach (first_row[i]) send_pixel(first_row[i]);
        // window around (2,2) all 255: sum 2295, mean 255, last word of the frame
        repeat (3) begin
            send_pixel(8'h80);
            repeat (3) send_pixel(8'hFF);
        end
    endtask

    // resize in the middle of a frame; counters keep running
    task automatic test_mid_frame_resize();
        wait_idle();
        // stray bits above the width field, height saturates to the tallest frame
        set_frame(13'h1806, 13'h1FFF);
        send_rows(2, 6, PIX_ANY);
        repeat (5) send_pixel(pick_pixel(PIX_ANY));
        wait_idle();
        // column already past the new row end: next word closes row 2,
        // and row 3 then ends the frame at the minimum height
        set_frame(13'h0003, 13'h0005);
        repeat (5) send_pixel(pick_pixel(PIX_ANY));
    endtask

    // full-width rows fill every line-store entry, then narrow rows finish the frame
    task automatic test_wide_lines();
        wait_idle();
        set_frame(13'd1023, 13'd4);
        send_rows(2, LINE_DEPTH, PIX_ANY);
        wait_idle();
        set_frame(13'd8, 13'd4);
        send_rows(2, 8, PIX_ANY);
    endtask

    // receiver stays off long enough for the block to fill and drop o_in_ready
    task automatic test_back_pressure();
        wait_idle();
        set_frame(13'd16, 13'd8);
        hold_off_left = 300;
        send_rows(8, 16, PIX_ANY);
    endtask

    // whole frames of random size and content, resized only at frame boundaries
    task automatic test_random_frames(input int unsigned item_goal);
        int unsigned                    sent_count;
        int unsigned                    rows;
        int unsigned                    cols;
        logic [bbd_pkg::CFG_DATA_W-1:0] width_data;
        logic [bbd_pkg::CFG_DATA_W-1:0] height_data;
        t_pix_style                     style;
        sent_count = 0;
        while (sent_count < item_goal) begin
            // mostly legal small widths, now and then odd or below the minimum
            if ($urandom_range(0, 3) == 0) begin
                width_data = bbd_pkg::CFG_DATA_W'($urandom_range(0, 7));
            end else begin
                width_data = bbd_pkg::CFG_DATA_W'($urandom_range(8, 24));
            end
            if ($urandom_range(0, 4) == 0) begin
                width_data[bbd_pkg::CFG_DATA_W-1:bbd_pkg::WIDTH_W] =
                    (bbd_pkg::CFG_DATA_W - bbd_pkg::WIDTH_W)'($urandom);
            end
            height_data = bbd_pkg::CFG_DATA_W'($urandom_range(0, 12));
            case ($urandom_range(0, 9))
                0:       style = PIX_RAILS;
                1:       style = PIX_DARK;
                2:       style = PIX_BRIGHT;
                default: style = PIX_ANY;
            endcase
            wait_idle();
            set_frame(width_data, height_data);
            cols = clamp_dim(width_reg, LINE_DEPTH);
            rows = clamp_dim(height_reg, bbd_pkg::MAX_HEIGHT);
            send_rows(rows, cols, style);
            sent_count += rows * cols;
        end
    endtask

    // result checker and receiver, both on the sampled pre-edge values
    always @(posedge i_clk) begin
        t_kept_pixel due;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (kept_due.size() == 0) begin
                $error("unexpected word: blurred_value %0d plain_value %0d last_of_frame %0b",
                       o_blurred_value, o_plain_value, o_last_of_frame);
                error_count++;
            end else begin
                due = kept_due.pop_front();
                if (o_blurred_value !== due.blurred) begin
                    $error("blurred_value: expected %0d, actual %0d",
                           due.blurred, o_blurred_value);
                    error_count++;
                end
                if (o_plain_value !== due.plain) begin
                    $error("plain_value: expected %0d, actual %0d", due.plain, o_plain_value);
                    error_count++;
                end
                if (o_last_of_frame !== due.last) begin
                    $error("last_of_frame: expected %0b, actual %0b",
                           due.last, o_last_of_frame);
                    error_count++;
                end
            end
        end
        // long hold-off first, otherwise random stalls
        if (hold_off_left > 0) begin
            i_out_ready <= 1'b0;
            hold_off_left--;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= ready_stall_pct);
        end
    end

    initial begin
        clear_blur_state();
        send_gap_pct    = 21;
        ready_stall_pct = 52;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_corner_frame();
        test_mid_frame_resize();
        test_wide_lines();
        test_random_frames(175);
        // sender slow, receiver eager
        send_gap_pct    = 52;
        ready_stall_pct = 21;
        test_random_frames(175);
        // no idling on either side
        send_gap_pct    = 0;
        ready_stall_pct = 0;
        test_back_pressure();
        test_random_frames(175);
        wait_idle();
        if (error_count == 0) begin
            $display("box_blur_decimate_2to1_top_tb passed");
        end else begin
            $display("box_blur_decimate_2to1_top_tb failed");
        end
        $finish;
    end

    // hang guard
    initial begin
        #(RUN_LIMIT_NS);
        $display("box_blur_decimate_2to1_top_tb failed");
        $finish;
    end

endmodule

// ===== box_blur_decimate_2to1_top.f =====
design/bbd_pkg.sv
design/bbd_ram.sv
design/bbd_window.sv
design/bbd_mean.sv
design/box_blur_decimate_2to1_top.sv
verif/box_blur_decimate_2to1_top_tb.sv
